FILE: rtl/lbg_pkg.sv
// lbg_pkg: shared constants, widths and payload types of the bar-graph character generator
// no dependencies; every other rtl file refers to it by scoped names
`default_nettype none

package lbg_pkg;

  // bar geometry
  localparam int MAX_BAR_CHARS   = 16;
  localparam int PIXELS_PER_CELL = 5;

  // field widths fixed by the interface
  localparam int PROG_W  = 16;
  localparam int LEN_W   = 5;
  localparam int SCALE_W = 16;
  localparam int CODE_W  = 3;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 16;

  // register reset values
  localparam logic [LEN_W-1:0]   BAR_LENGTH_RESET = LEN_W'(16);
  localparam logic [SCALE_W-1:0] FULL_SCALE_RESET = SCALE_W'(100);

  // register indexes
  localparam logic [IDX_W-1:0] REG_BAR_LENGTH = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FULL_SCALE = IDX_W'(1);

  // scaling and divider widths
  localparam int P_W        = $clog2(PIXELS_PER_CELL + 1);
  localparam int PROD_W     = PROG_W + LEN_W;
  localparam int DIVIDEND_W = PROD_W + P_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (DIVIDEND_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DQ_W       = DIV_STAGES * DIV_BITS;

  // saturated pixel count
  localparam int PIX_MAX = MAX_BAR_CHARS * PIXELS_PER_CELL;
  localparam int PIX_W   = $clog2(PIX_MAX + 1);

  // glyph of a fully covered cell, cut to the code width
  localparam logic [CODE_W-1:0] FULL_CODE = CODE_W'(PIXELS_PER_CELL);

  // item after scaling: dividend and effective bar length
  typedef struct packed {
    logic [DIVIDEND_W-1:0] dividend;
    logic [LEN_W-1:0]      len;
  } scale_item_t;

  // item after division: pixel count and effective bar length
  typedef struct packed {
    logic [DQ_W-1:0]  quotient;
    logic [LEN_W-1:0] len;
  } pix_item_t;

endpackage

`default_nettype wire

FILE: rtl/lbg_if.sv
// lbg_if: valid/ready channel interfaces for progress input, character output and register writes
// depends on lbg_pkg for field widths
`default_nettype none

interface lbg_in_if;
  logic                       valid;
  logic                       ready;
  logic [lbg_pkg::PROG_W-1:0] progress;

  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

interface lbg_out_if;
  logic                       valid;
  logic                       ready;
  logic [lbg_pkg::CODE_W-1:0] char_code;
  logic                       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface lbg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lbg_pkg::IDX_W-1:0]  index;
  logic [lbg_pkg::DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lcd_bargraph_char_generator_unit.sv
// lcd_bargraph_char_generator_unit: top level with configuration registers and the pipeline
// depends on lbg_pkg, lbg_if, lbg_scale, lbg_div, lbg_emit
`default_nettype none

// Takes one progress value per transaction and returns bar_length character codes,
// one per cell in cell order, the final one with last set (0 empty, 1..4 partial,
// 5 full). A value is scaled to pixels = progress * bar_length * 5 / full_scale by
// a two-stage multiplier and a six-stage divider (four quotient bits per stage);
// the character stage then drives one code per cycle while the output is ready. An
// input transaction can be taken every cycle while the pipeline has room, so a
// stream of items is bounded by the single character output, which gives one code
// per cell. A bar length of zero produces no transaction; lengths above 16 are cut
// to 16; a full scale of zero gives all full cells. Registers: index 0 bar_length
// (reset 16), index 1 full_scale (reset 100); write them only while no item is in
// flight.
module lcd_bargraph_char_generator_unit (
  input wire logic  clk,
  input wire logic  rst,
  lbg_in_if.sink    item,
  lbg_out_if.source chars,
  lbg_cfg_if.sink   cfg
);

  logic [lbg_pkg::LEN_W-1:0]   bar_length;
  logic [lbg_pkg::SCALE_W-1:0] full_scale;
  logic [lbg_pkg::LEN_W-1:0]   len_eff;

  logic                        sc_valid;
  logic                        sc_ready;
  lbg_pkg::scale_item_t        sc_data;
  logic                        dv_valid;
  logic                        dv_ready;
  lbg_pkg::pix_item_t          dv_data;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_length <= lbg_pkg::BAR_LENGTH_RESET;
      full_scale <= lbg_pkg::FULL_SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lbg_pkg::REG_BAR_LENGTH: bar_length <= cfg.data[lbg_pkg::LEN_W-1:0];
        lbg_pkg::REG_FULL_SCALE: full_scale <= cfg.data[lbg_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp bar length to the supported cell count
  assign len_eff = (32'(bar_length) > lbg_pkg::MAX_BAR_CHARS) ?
                   lbg_pkg::LEN_W'(lbg_pkg::MAX_BAR_CHARS) : bar_length;

  lbg_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .len       (len_eff),
    .dst_valid (sc_valid),
    .dst_ready (sc_ready),
    .dst_data  (sc_data)
  );

  lbg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (full_scale),
    .src_valid (sc_valid),
    .src_ready (sc_ready),
    .src_data  (sc_data),
    .dst_valid (dv_valid),
    .dst_ready (dv_ready),
    .dst_data  (dv_data)
  );

  lbg_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .src_valid (dv_valid),
    .src_ready (dv_ready),
    .src_data  (dv_data),
    .chars     (chars)
  );

endmodule

`default_nettype wire

FILE: rtl/lbg_scale.sv
// lbg_scale: two pipeline stages forming progress * bar length * pixels per cell
// depends on lbg_pkg and lbg_in_if
`default_nettype none

module lbg_scale (
  input  wire logic                      clk,
  input  wire logic                      rst,
  lbg_in_if.sink                         item,
  input  wire logic [lbg_pkg::LEN_W-1:0] len,
  output      logic                      dst_valid,
  input  wire logic                      dst_ready,
  output      lbg_pkg::scale_item_t      dst_data
);

  logic                         prod_valid;
  logic [lbg_pkg::PROD_W-1:0]   prod;
  logic [lbg_pkg::LEN_W-1:0]    prod_len;
  logic                         prod_ready;

  // stall chain
  assign prod_ready = !prod_valid || !dst_valid || dst_ready;
  assign item.ready = prod_ready;

  // stage one: progress times bar length; empty bars are dropped here
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= item.valid && (len != '0);
    end
    if (prod_ready) begin
      prod     <= lbg_pkg::PROD_W'(item.progress) * lbg_pkg::PROD_W'(len);
      prod_len <= len;
    end
  end

  // stage two: times pixels per cell
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (dst_ready || !dst_valid) begin
      dst_valid <= prod_valid;
    end
    if (dst_ready || !dst_valid) begin
      dst_data.dividend <= lbg_pkg::DIVIDEND_W'(prod) *
                           lbg_pkg::DIVIDEND_W'(lbg_pkg::PIXELS_PER_CELL);
      dst_data.len      <= prod_len;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lbg_div.sv
// lbg_div: pipelined restoring divider, a few quotient bits per stage
// depends on lbg_pkg; divisor is the full scale register, kept stable by the user while items are in flight, unchecked
`default_nettype none

module lbg_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lbg_pkg::SCALE_W-1:0] divisor,
  input  wire logic                        src_valid,
  output      logic                        src_ready,
  input  wire lbg_pkg::scale_item_t        src_data,
  output      logic                        dst_valid,
  input  wire logic                        dst_ready,
  output      lbg_pkg::pix_item_t          dst_data
);

  localparam int N = lbg_pkg::DIV_STAGES;

  logic                          vld   [N];
  logic [lbg_pkg::SCALE_W-1:0]   rem   [N];
  logic [lbg_pkg::DQ_W-1:0]      dq    [N];
  logic [lbg_pkg::LEN_W-1:0]     len_q [N];
  logic                          rdy   [N+1];

  assign rdy[N]    = dst_ready;
  assign src_ready = rdy[0];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                        v_in;
    logic [lbg_pkg::SCALE_W-1:0] r_in;
    logic [lbg_pkg::DQ_W-1:0]    q_in;
    logic [lbg_pkg::LEN_W-1:0]   l_in;
    logic [lbg_pkg::SCALE_W-1:0] r_nxt;
    logic [lbg_pkg::DQ_W-1:0]    q_nxt;
    logic [lbg_pkg::SCALE_W:0]   trial;

    // stage inputs
    if (s == 0) begin : g_first
      assign v_in = src_valid;
      assign r_in = '0;
      assign q_in = lbg_pkg::DQ_W'(src_data.dividend);
      assign l_in = src_data.len;
    end else begin : g_rest
      assign v_in = vld[s-1];
      assign r_in = rem[s-1];
      assign q_in = dq[s-1];
      assign l_in = len_q[s-1];
    end

    assign rdy[s] = !vld[s] || rdy[s+1];

    // shift-subtract steps; a zero divisor yields an all-ones quotient
    always_comb begin
      r_nxt = r_in;
      q_nxt = q_in;
      trial = '0;
      for (int b = 0; b < lbg_pkg::DIV_BITS; b++) begin
        trial = {r_nxt, q_nxt[lbg_pkg::DQ_W-1]};
        q_nxt = {q_nxt[lbg_pkg::DQ_W-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
          trial    = trial - {1'b0, divisor};
          q_nxt[0] = 1'b1;
        end
        r_nxt = trial[lbg_pkg::SCALE_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= v_in;
      end
      if (rdy[s]) begin
        rem[s]   <= r_nxt;
        dq[s]    <= q_nxt;
        len_q[s] <= l_in;
      end
    end
  end

  assign dst_valid         = vld[N-1];
  assign dst_data.quotient = dq[N-1];
  assign dst_data.len      = len_q[N-1];

endmodule

`default_nettype wire

FILE: rtl/lbg_emit.sv
// lbg_emit: turns a pixel count into one character code per cell, through an output register
// depends on lbg_pkg and lbg_out_if
`default_nettype none

module lbg_emit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               src_valid,
  output      logic               src_ready,
  input  wire lbg_pkg::pix_item_t src_data,
  lbg_out_if.source               chars
);

  logic [lbg_pkg::PIX_W-1:0]  rest_pix;
  logic [lbg_pkg::LEN_W-1:0]  cells_left;
  logic                       adv;
  logic                       more;
  logic [lbg_pkg::PIX_W-1:0]  src_pix;
  logic [lbg_pkg::PIX_W-1:0]  value;
  logic [lbg_pkg::LEN_W-1:0]  cnt;
  logic [lbg_pkg::CODE_W-1:0] char_code_next;
  logic                       last_next;
  logic [lbg_pkg::PIX_W-1:0]  rest_pix_next;
  logic [lbg_pkg::LEN_W-1:0]  cells_left_next;

  assign adv       = !chars.valid || chars.ready;
  assign more      = (cells_left != '0);
  assign src_ready = adv && !more;

  // saturate the quotient; anything past the whole bar is all full cells
  assign src_pix = (src_data.quotient > lbg_pkg::DQ_W'(lbg_pkg::PIX_MAX)) ?
                   lbg_pkg::PIX_W'(lbg_pkg::PIX_MAX) :
                   src_data.quotient[lbg_pkg::PIX_W-1:0];

  // next cell: full while pixels remain, then the partial remainder, then empty
  always_comb begin
    value = more ? rest_pix : src_pix;
    cnt   = more ? cells_left : src_data.len;
    if (value >= lbg_pkg::PIX_W'(lbg_pkg::PIXELS_PER_CELL)) begin
      char_code_next = lbg_pkg::FULL_CODE;
      rest_pix_next  = value - lbg_pkg::PIX_W'(lbg_pkg::PIXELS_PER_CELL);
    end else begin
      char_code_next = lbg_pkg::CODE_W'(value);
      rest_pix_next  = '0;
    end
    cells_left_next = cnt - lbg_pkg::LEN_W'(1);
    last_next       = (cnt == lbg_pkg::LEN_W'(1));
  end

  // output register and cell counter
  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      cells_left  <= '0;
    end else if (adv) begin
      if (more || src_valid) begin
        chars.valid <= 1'b1;
        cells_left  <= cells_left_next;
      end else begin
        chars.valid <= 1'b0;
      end
    end
    if (adv && (more || src_valid)) begin
      chars.char_code <= char_code_next;
      chars.last      <= last_next;
      rest_pix        <= rest_pix_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/lbg_bar_checker.sv
`timescale 1ns / 100ps
// lbg_bar_checker: watches the progress, register and character channels of the bar-graph unit,
// predicts the character codes of each bar and compares every character transaction
// depends on lbg_pkg and the channel interfaces of lbg_if

module lbg_bar_checker (
  input  logic clk,
  input  logic rst,
  lbg_in_if    item,
  lbg_out_if   chars,
  lbg_cfg_if   cfg,
  output int   mismatches,
  output int   pending,
  output int   bars_seen,
  output int   glyphs_checked
);
  import lbg_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              last;
  } glyph_t;

  // register mirror and codes still owed by the unit
  logic [LEN_W-1:0]   bar_len;
  logic [SCALE_W-1:0] scale;
  glyph_t             glyph_q[$];

  // queue the codes of one bar under the current register settings
  function automatic void predict_bar(logic [PROG_W-1:0] progress);
    int unsigned     cells;
    longint unsigned pixels;
    longint unsigned start;
    glyph_t          g;
    cells = (bar_len > MAX_BAR_CHARS) ? MAX_BAR_CHARS : bar_len;
    // a zero full scale saturates the pixel count
    if (scale == '0) pixels = '1;
    else pixels = (64'(progress) * cells * PIXELS_PER_CELL) / scale;
    for (int i = 0; i < cells; i++) begin
      start = i * PIXELS_PER_CELL;
      if (start + PIXELS_PER_CELL <= pixels) g.char_code = CODE_W'(PIXELS_PER_CELL);
      else if (start > pixels) g.char_code = '0;
      else g.char_code = CODE_W'(pixels % PIXELS_PER_CELL);
      g.last = (i == cells - 1);
      glyph_q.push_back(g);
    end
  endfunction

  // track writes and inputs, check each character transaction
  always @(posedge clk) begin
    glyph_t want;
    if (rst) begin
      bar_len        = BAR_LENGTH_RESET;
      scale          = FULL_SCALE_RESET;
      glyph_q.delete();
      pending        = 0;
      mismatches     = 0;
      bars_seen      = 0;
      glyphs_checked = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_BAR_LENGTH) bar_len = cfg.data[LEN_W-1:0];
        else if (cfg.index == REG_FULL_SCALE) scale = cfg.data[SCALE_W-1:0];
      end
      if (item.valid && item.ready) begin
        predict_bar(item.progress);
        bars_seen++;
      end
      if (chars.valid && chars.ready) begin
        glyphs_checked++;
        if (glyph_q.size() == 0) begin
          $error("char_code %0d last %0d arrived with no character expected",
                 chars.char_code, chars.last);
          mismatches++;
        end else begin
          want = glyph_q.pop_front();
          if (chars.char_code !== want.char_code) begin
            $error("char_code: expected %0d, got %0d", want.char_code, chars.char_code);
            mismatches++;
          end
          if (chars.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, chars.last);
            mismatches++;
          end
        end
      end
      pending = glyph_q.size();
    end
  end

endmodule

FILE: tb/tb_lcd_bargraph_char_generator_unit.sv
`timescale 1ns / 100ps
// tb_lcd_bargraph_char_generator_unit: drives progress values and register writes into the unit
// under three idle mixes; depends on lbg_pkg, lbg_if, the unit and lbg_bar_checker

module tb_lcd_bargraph_char_generator_unit;
  import lbg_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_LIMIT   = 2000;
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(15);

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_gap_pct = 11;
  int hold_pct     = 78;
  int idle_cycles  = 0;
  int settings_run = 0;
  int mismatches, pending, bars_seen, glyphs_checked;
  logic [SCALE_W-1:0] cur_scale = FULL_SCALE_RESET;

  lbg_in_if  item_ch ();
  lbg_out_if chars_ch ();
  lbg_cfg_if cfg_ch ();

  lcd_bargraph_char_generator_unit dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .chars (chars_ch),
    .cfg   (cfg_ch)
  );

  lbg_bar_checker bar_check (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .chars          (chars_ch),
    .cfg            (cfg_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .bars_seen      (bars_seen),
    .glyphs_checked (glyphs_checked)
  );

  always #5 clk = ~clk;

  // character sink back-pressure
  always @(negedge clk) begin
    chars_ch.ready <= ($urandom_range(99) >= hold_pct);
  end

  // watchdog: too long without any transaction
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (chars_ch.valid && chars_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lcd_bargraph_char_generator_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one progress transaction, with random gaps before it
  task automatic send_progress(logic [PROG_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid    = 1'b1;
    item_ch.progress = value;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // hold off input until every expected character has come
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // new register settings once the unit is idle; bars of length zero leave no trace,
  // so let the pipeline empty before writing
  task automatic apply_setting(logic [DATA_W-1:0] len_data, logic [DATA_W-1:0] scale_data);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_reg(REG_BAR_LENGTH, len_data);
    write_reg(REG_FULL_SCALE, scale_data);
    cur_scale = scale_data[SCALE_W-1:0];
    settings_run++;
  endtask

  initial begin
    logic [PROG_W-1:0] reset_run[13] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7,
                                         16'd50, 16'd100, 16'd101, 16'hAAAA, 16'h5555,
                                         16'hFFFF};
    logic [DATA_W-1:0] len_data;
    logic [DATA_W-1:0] scale_data;
    logic [PROG_W-1:0] value;
    int unsigned       len_val;

    item_ch.valid    = 1'b0;
    item_ch.progress = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_BAR_LENGTH;
    cfg_ch.data      = '0;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // reset settings: empty, each partial code, full cells, over-range values
    foreach (reset_run[i]) send_progress(reset_run[i]);

    // a write to an unused index changes nothing
    wait_drained();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_progress(16'd50);

    // single-cell bar at the widest scale
    apply_setting(16'd1, 16'hFFFF);
    send_progress(16'hFFFF);
    send_progress(16'd13107);
    send_progress(16'd13106);
    send_progress(16'd0);

    // zero bar length, upper data bits set: no characters at all
    apply_setting(16'hFFE0, 16'd0);
    send_progress(16'hFFFF);
    send_progress(16'd1);

    // length above the maximum is cut, zero scale saturates
    apply_setting(16'h001F, 16'd0);
    send_progress(16'd0);

    // smallest scale
    apply_setting(16'd16, 16'd1);
    send_progress(16'd1);
    send_progress(16'd0);

    // random settings and progress values under each idle mix
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_gap_pct = 11; hold_pct = 78; end
        1: begin send_gap_pct = 78; hold_pct = 11; end
        default: begin send_gap_pct = 0; hold_pct = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        if ($urandom_range(7) == 0) len_val = $urandom_range(1) ? 0 : $urandom_range(17, 31);
        else len_val = $urandom_range(1, 16);
        len_data = {11'($urandom), 5'(len_val)};
        case ($urandom_range(9))
          0:       scale_data = '0;
          1:       scale_data = 16'hFFFF;
          2, 3, 4: scale_data = DATA_W'($urandom_range(1, 300));
          default: scale_data = DATA_W'($urandom_range(1, 65535));
        endcase
        apply_setting(len_data, scale_data);
        for (int n = 0; n < 7; n++) begin
          if (s == 1 && n == 4) wait_drained();
          case ($urandom_range(5))
            0:       value = $urandom_range(1) ? '0 : '1;
            1, 2:    value = PROG_W'($urandom_range(0, cur_scale));
            3:       value = PROG_W'(cur_scale + $urandom_range(0, 3));
            default: value = PROG_W'($urandom);
          endcase
          send_progress(value);
        end
      end
    end

    // let the last bars drain
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("summary: %0d progress values over %0d register settings, %0d characters checked",
             bars_seen, settings_run, glyphs_checked);
    $display("summary: sender-heavy, sink-heavy and gap-free idle mixes were all exercised");
    if (mismatches == 0) begin
      $display("tb_lcd_bargraph_char_generator_unit: done, clean");
    end else begin
      $display("tb_lcd_bargraph_char_generator_unit: done, errors");
    end
    $finish;
  end

endmodule
